/* design/chps_pkg.sv */
// ----------------------------------------------------------------------------
// chps_pkg
// Shared types and character codes for the cookie header pair splitter.
// ----------------------------------------------------------------------------
`default_nettype none

package chps_pkg;

	localparam int OFS_W = 12;

	localparam logic [7:0] CH_EQUAL = 8'h3D;  // '='
	localparam logic [7:0] CH_SEMI  = 8'h3B;  // ';'
	localparam logic [7:0] CH_QUOTE = 8'h22;  // '"'
	localparam logic [7:0] CH_COLON = 8'h3A;  // ':'
	localparam logic [7:0] CH_SPACE = 8'h20;  // ' '

	localparam logic [OFS_W-1:0] MAX_PAIR_LEN_RST = 12'd4095;

	typedef enum logic [2:0] {
		PH_SKIP  = 3'b001,
		PH_KEY   = 3'b010,
		PH_VALUE = 3'b100
	} phase_t;

	typedef struct packed {
		logic [7:0] ch;
		logic       end_of_header;
	} item_t;

	typedef struct packed {
		logic             pair_valid;
		logic [OFS_W-1:0] key_start;
		logic [OFS_W-1:0] key_length;
		logic [OFS_W-1:0] value_start;
		logic [OFS_W-1:0] value_length;
		logic             header_end;
	} result_t;

endpackage

`default_nettype wire

/* design/cookie_header_pair_splitter.sv */
// ----------------------------------------------------------------------------
// cookie_header_pair_splitter
// Splits a Cookie header, one byte per word, into key/value offset records.
// ----------------------------------------------------------------------------
// Takes one header byte per cycle, then a terminator word, and emits one
// record per accepted key/value pair (offsets and lengths, 12 bits each); the
// terminator's record has header_end set and also carries any pair it closes.
// An input register feeds the parse logic, which loads the output register.
// Sustained rate is one word per cycle while out_ready
// is high; a word that yields no record still advances only when the output
// register is free or being drained in the same cycle. max_pair_length may be
// written only while the block is idle.
`default_nettype none

module cookie_header_pair_splitter
	import chps_pkg::*;
#(
	parameter int MAX_HEADER_LEN = 4096
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             cfg_wr_en,
	input  wire logic [OFS_W-1:0] cfg_wr_data,
	input  wire logic             in_valid,
	output logic                  in_ready,
	input  wire logic [7:0]       ch,
	input  wire logic             end_of_header,
	output logic                  out_valid,
	input  wire logic             out_ready,
	output logic                  pair_valid,
	output logic [OFS_W-1:0]      key_start,
	output logic [OFS_W-1:0]      key_length,
	output logic [OFS_W-1:0]      value_start,
	output logic [OFS_W-1:0]      value_length,
	output logic                  header_end
);

	logic [OFS_W-1:0] max_len_q;
	logic             item_v;
	item_t            item;
	logic             out_free;
	logic             fire;
	logic             res_v;
	result_t          res;
	logic             out_valid_s2;
	result_t          res_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_len_q <= MAX_PAIR_LEN_RST;
		end else if (cfg_wr_en) begin
			max_len_q <= cfg_wr_data;
		end
	end

	assign out_free = !out_valid_s2 || out_ready;
	assign fire     = item_v && out_free;

	chps_in_stage u_in (
		.clk           (clk),
		.arst_n        (arst_n),
		.in_valid      (in_valid),
		.in_ready      (in_ready),
		.ch            (ch),
		.end_of_header (end_of_header),
		.advance       (out_free),
		.item_v        (item_v),
		.item          (item)
	);

	chps_parser #(
		.MAX_HEADER_LEN (MAX_HEADER_LEN)
	) u_parser (
		.clk             (clk),
		.arst_n          (arst_n),
		.fire            (fire),
		.item            (item),
		.max_pair_length (max_len_q),
		.res_v           (res_v),
		.res             (res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_s2 <= 1'b0;
		end else if (out_free) begin
			out_valid_s2 <= fire && res_v;
		end
	end

	always_ff @(posedge clk) begin
		if (fire && res_v) begin
			res_s2 <= res;
		end
	end

	assign out_valid    = out_valid_s2;
	assign pair_valid   = res_s2.pair_valid;
	assign key_start    = res_s2.key_start;
	assign key_length   = res_s2.key_length;
	assign value_start  = res_s2.value_start;
	assign value_length = res_s2.value_length;
	assign header_end   = res_s2.header_end;

endmodule

`default_nettype wire

/* design/chps_in_stage.sv */
// ----------------------------------------------------------------------------
// chps_in_stage
// Input register: holds one header word until the parser takes it.
// ----------------------------------------------------------------------------
`default_nettype none

module chps_in_stage
	import chps_pkg::*;
(
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       in_valid,
	output logic            in_ready,
	input  wire logic [7:0] ch,
	input  wire logic       end_of_header,
	input  wire logic       advance,
	output logic            item_v,
	output item_t           item
);

	logic  item_v_s1;
	item_t item_s1;

	// take a new word when empty or whenever the held one leaves in this cycle
	assign in_ready = !item_v_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			item_v_s1 <= 1'b0;
		end else if (in_ready) begin
			item_v_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			item_s1.ch            <= ch;
			item_s1.end_of_header <= end_of_header;
		end
	end

	assign item_v = item_v_s1;
	assign item   = item_s1;

endmodule

`default_nettype wire

/* design/chps_parser.sv */
// ----------------------------------------------------------------------------
// chps_parser
// Per-byte cookie parse state and pair finishing logic.
// ----------------------------------------------------------------------------
`default_nettype none

module chps_parser
	import chps_pkg::*;
#(
	parameter int MAX_HEADER_LEN = 4096
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             fire,
	input  wire item_t            item,
	input  wire logic [OFS_W-1:0] max_pair_length,
	output logic                  res_v,
	output result_t               res
);

	localparam int POS_W = $clog2(MAX_HEADER_LEN + 1);
	localparam logic [POS_W-1:0] POS_LIMIT = POS_W'(MAX_HEADER_LEN);

	phase_t           phase_q, phase_d;
	logic             in_quotes_q, in_quotes_d;
	logic [POS_W-1:0] byte_pos_q, byte_pos_d;
	logic [OFS_W-1:0] key_start_q, key_start_d;
	logic [POS_W-1:0] trim_key_len_q, trim_key_len_d;
	logic [POS_W-1:0] raw_key_len_q, raw_key_len_d;
	logic [OFS_W-1:0] val_start_q, val_start_d;
	logic [POS_W-1:0] raw_val_len_q, raw_val_len_d;
	logic             val_open_quote_q, val_open_quote_d;
	logic             last_quote_q, last_quote_d;

	logic             fin_ok;
	logic [OFS_W-1:0] fin_vs;
	logic [POS_W-1:0] fin_vl;
	logic [POS_W:0]   fin_sum;
	logic [OFS_W-1:0] pos12;
	logic             is_quote;

	// finish of the open pair, evaluated from current state
	always_comb begin
		fin_vs = val_start_q;
		fin_vl = '0;
		fin_ok = 1'b0;
		case (phase_q)
			PH_KEY: begin
				fin_vs = key_start_q + raw_key_len_q[OFS_W-1:0] + OFS_W'(1);
				fin_ok = 1'b1;
			end
			PH_VALUE: begin
				fin_vl = raw_val_len_q;
				fin_ok = 1'b1;
				// strip one pair of enclosing quotes; lone quote gives empty value
				if (raw_val_len_q != '0 && val_open_quote_q && last_quote_q) begin
					fin_vs = val_start_q + OFS_W'(1);
					fin_vl = (raw_val_len_q >= POS_W'(2)) ? raw_val_len_q - POS_W'(2) : '0;
				end
			end
			default: fin_ok = 1'b0;
		endcase
		fin_sum = {1'b0, trim_key_len_q} + {1'b0, fin_vl};
		if (trim_key_len_q == '0 || fin_sum > (POS_W+1)'(max_pair_length)) begin
			fin_ok = 1'b0;
		end
	end

	assign pos12    = byte_pos_q[OFS_W-1:0];
	assign is_quote = (item.ch == CH_QUOTE);

	always_comb begin
		phase_d          = phase_q;
		in_quotes_d      = in_quotes_q;
		byte_pos_d       = byte_pos_q;
		key_start_d      = key_start_q;
		trim_key_len_d   = trim_key_len_q;
		raw_key_len_d    = raw_key_len_q;
		val_start_d      = val_start_q;
		raw_val_len_d    = raw_val_len_q;
		val_open_quote_d = val_open_quote_q;
		last_quote_d     = last_quote_q;

		res_v            = 1'b0;
		res.pair_valid   = fin_ok;
		res.key_start    = fin_ok ? key_start_q : '0;
		res.key_length   = fin_ok ? trim_key_len_q[OFS_W-1:0] : '0;
		res.value_start  = fin_ok ? fin_vs : '0;
		res.value_length = fin_ok ? fin_vl[OFS_W-1:0] : '0;
		res.header_end   = item.end_of_header;

		if (item.end_of_header) begin
			res_v            = 1'b1;
			phase_d          = PH_SKIP;
			in_quotes_d      = 1'b0;
			byte_pos_d       = '0;
			key_start_d      = '0;
			trim_key_len_d   = '0;
			raw_key_len_d    = '0;
			val_start_d      = '0;
			raw_val_len_d    = '0;
			val_open_quote_d = 1'b0;
			last_quote_d     = 1'b0;
		end else if (byte_pos_q < POS_LIMIT) begin
			byte_pos_d = byte_pos_q + POS_W'(1);
			case (phase_q)
				PH_KEY: begin
					if (item.ch == CH_SEMI) begin
						res_v   = fin_ok;
						phase_d = PH_SKIP;
					end else if (item.ch == CH_EQUAL) begin
						phase_d          = PH_VALUE;
						val_start_d      = pos12 + OFS_W'(1);
						raw_val_len_d    = '0;
						in_quotes_d      = 1'b0;
						val_open_quote_d = 1'b0;
						last_quote_d     = 1'b0;
					end else begin
						raw_key_len_d = raw_key_len_q + POS_W'(1);
						if (item.ch != CH_SPACE) begin
							trim_key_len_d = raw_key_len_q + POS_W'(1);
						end
					end
				end
				PH_VALUE: begin
					if (item.ch == CH_SEMI && !in_quotes_q) begin
						res_v   = fin_ok;
						phase_d = PH_SKIP;
					end else begin
						if (raw_val_len_q == '0) begin
							val_open_quote_d = is_quote;
						end
						last_quote_d  = is_quote;
						in_quotes_d   = in_quotes_q ^ is_quote;
						raw_val_len_d = raw_val_len_q + POS_W'(1);
					end
				end
				default: begin
					if (item.ch != CH_SPACE && item.ch != CH_SEMI && item.ch != CH_COLON) begin
						key_start_d = pos12;
						if (item.ch == CH_EQUAL) begin
							// empty key: parse the value, drop it at the end
							raw_key_len_d    = '0;
							trim_key_len_d   = '0;
							phase_d          = PH_VALUE;
							val_start_d      = pos12 + OFS_W'(1);
							raw_val_len_d    = '0;
							in_quotes_d      = 1'b0;
							val_open_quote_d = 1'b0;
							last_quote_d     = 1'b0;
						end else begin
							raw_key_len_d  = POS_W'(1);
							trim_key_len_d = POS_W'(1);
							phase_d        = PH_KEY;
						end
					end
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q          <= PH_SKIP;
			in_quotes_q      <= 1'b0;
			byte_pos_q       <= '0;
			key_start_q      <= '0;
			trim_key_len_q   <= '0;
			raw_key_len_q    <= '0;
			val_start_q      <= '0;
			raw_val_len_q    <= '0;
			val_open_quote_q <= 1'b0;
			last_quote_q     <= 1'b0;
		end else if (fire) begin
			phase_q          <= phase_d;
			in_quotes_q      <= in_quotes_d;
			byte_pos_q       <= byte_pos_d;
			key_start_q      <= key_start_d;
			trim_key_len_q   <= trim_key_len_d;
			raw_key_len_q    <= raw_key_len_d;
			val_start_q      <= val_start_d;
			raw_val_len_q    <= raw_val_len_d;
			val_open_quote_q <= val_open_quote_d;
			last_quote_q     <= last_quote_d;
		end
	end

endmodule

`default_nettype wire

/* design/chps_checker.sv */
// ----------------------------------------------------------------------------
// chps_checker
// Port-level checks for the cookie header pair splitter.
// ----------------------------------------------------------------------------
`default_nettype none

module chps_checker
	import chps_pkg::*;
(
	input wire logic             clk,
	input wire logic             arst_n,
	input wire logic             out_valid,
	input wire logic             out_ready,
	input wire logic             pair_valid,
	input wire logic [OFS_W-1:0] key_start,
	input wire logic [OFS_W-1:0] key_length,
	input wire logic [OFS_W-1:0] value_start,
	input wire logic [OFS_W-1:0] value_length,
	input wire logic             header_end
);

	// every record carries a pair, the header end, or both
	a_rec_meaning: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (pair_valid || header_end))
		else $error("record with neither pair nor header end");

	// empty keys are never reported
	a_key_nonempty: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && pair_valid) |-> (key_length != '0))
		else $error("pair reported with empty key");

	// terminator record without a pair has all offset fields cleared
	a_end_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && header_end && !pair_valid) |->
		(key_start == '0 && key_length == '0 && value_start == '0 && value_length == '0))
		else $error("terminator record without pair has nonzero fields");

	// stalled record holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !out_ready) |=>
		(out_valid && $stable(pair_valid) && $stable(key_start) && $stable(key_length)
		 && $stable(value_start) && $stable(value_length) && $stable(header_end)))
		else $error("output record changed while stalled");

endmodule

bind cookie_header_pair_splitter chps_checker u_chps_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.out_valid    (out_valid),
	.out_ready    (out_ready),
	.pair_valid   (pair_valid),
	.key_start    (key_start),
	.key_length   (key_length),
	.value_start  (value_start),
	.value_length (value_length),
	.header_end   (header_end)
);

`default_nettype wire
